// File: hdl/bpma_pkg.sv
// Package for the band pixel metrics accumulator.
// Holds word types, command codes, sizes and the count clipping function.
// No dependencies.
package bpma_pkg;

  localparam int BAND_COUNT     = 8;
  localparam int BAND_IDX_BITS  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int COUNT_BITS     = 32;
  localparam int OUT_COUNT_BITS = 32;
  localparam int SUM_BITS       = 42;
  localparam int FRAC_BITS      = 8;
  localparam int DIV_BITS       = SUM_BITS + FRAC_BITS;
  localparam int DIVISOR_BITS   = COUNT_BITS + 1;
  localparam int DIV_CNT_BITS   = $clog2(DIV_BITS + 1);

  localparam int NUM_COUNTS = 5;
  localparam int NUM_SUMS   = 2;

  localparam int CNT_NEAR       = 0;
  localparam int CNT_ONE_SAT    = 1;
  localparam int CNT_ONE_UNSAT  = 2;
  localparam int CNT_TWO_SAT    = 3;
  localparam int CNT_TWO_UNSAT  = 4;
  localparam int SUM_ONE        = 0;
  localparam int SUM_TWO        = 1;

  localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
  localparam logic [1:0] CMD_REPORT     = 2'd1;
  localparam logic [1:0] CMD_CLEAR      = 2'd2;

  localparam logic [1:0] GAIN_ONE = 2'd0;
  localparam logic [1:0] GAIN_TWO = 2'd2;

  localparam logic [10:0] NEAR_MARGIN = 11'd3;
  localparam logic [9:0]  SAT_LEVEL   = 10'd1023;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] scan_number;
    logic        first_of_scan;
    logic [2:0]  band;
    logic [9:0]  sample;
    logic [9:0]  dark_level;
    logic [1:0]  gain_code;
  } item_t;

  typedef struct packed {
    logic [2:0]                report_band;
    logic [OUT_COUNT_BITS-1:0] near_dark_count;
    logic [OUT_COUNT_BITS-1:0] gain_one_saturated;
    logic [OUT_COUNT_BITS-1:0] gain_one_unsaturated;
    logic [OUT_COUNT_BITS-1:0] gain_two_saturated;
    logic [OUT_COUNT_BITS-1:0] gain_two_unsaturated;
    logic [SUM_BITS-1:0]       gain_one_mean;
    logic [SUM_BITS-1:0]       gain_two_mean;
  } report_t;

  typedef struct packed {
    logic acc_en;
    logic clr_all;
    logic capture;
    logic div_start;
    logic div_sel;
    logic store_one;
    logic store_two;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_busy;
  } dp_status_t;

  function automatic logic [OUT_COUNT_BITS-1:0] clip_count(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS+OUT_COUNT_BITS-1:0] wide;
    logic [COUNT_BITS+OUT_COUNT_BITS-1:0] lim;
    wide = (COUNT_BITS+OUT_COUNT_BITS)'(c);
    lim  = (COUNT_BITS+OUT_COUNT_BITS)'({OUT_COUNT_BITS{1'b1}});
    if (wide > lim) begin
      return {OUT_COUNT_BITS{1'b1}};
    end
    return wide[OUT_COUNT_BITS-1:0];
  endfunction

endpackage

// File: hdl/band_pixel_metrics_accumulator.sv
// Accumulate and clear words update the totals; the next word is accepted in the following cycle.
// A report word captures the band totals, then runs the divider twice (50 quotient bits each),
// one run per gain mean, storing each mean, and then loads the output register; the next word
// is accepted after that load, which waits while an earlier report is still in the output register.
// Synchronous active-high reset clears all per-band totals and the output valid at once.
module band_pixel_metrics_accumulator
  import bpma_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item_data,
  output logic    report_valid,
  input  logic    report_ready,
  output report_t report_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bpma_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .command    (item_data.command),
    .status     (status),
    .cmd        (cmd)
  );

  bpma_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item_data    (item_data),
    .cmd          (cmd),
    .status       (status),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report_data  (report_data)
  );

  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !status.div_busy)
    else $error("word accepted while divider busy");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !report_valid)
    else $error("output overwritten before taken");

  a_report_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(report_valid) |-> $past(cmd.out_load))
    else $error("report raised without load");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy && !item_ready)
    else $error("division started out of sequence");

endmodule

// File: hdl/bpma_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bpma_pkg for operand widths.
module bpma_div
  import bpma_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DIV_BITS-1:0]     dividend,
  input  logic [DIVISOR_BITS-1:0] divisor,
  output logic [DIV_BITS-1:0]     quotient,
  output logic                    busy,
  output logic                    done
);

  logic [DIV_CNT_BITS-1:0] count;
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS-1:0] dsr;
  logic [DIV_BITS-1:0]     work;
  logic [DIVISOR_BITS:0]   trial;
  logic [DIVISOR_BITS:0]   diff;
  logic                    fits;

  assign trial = {rem, work[DIV_BITS-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= DIV_CNT_BITS'(DIV_BITS);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsr  <= divisor;
      work <= dividend;
    end else if (count != '0) begin
      rem  <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
      work <= {work[DIV_BITS-2:0], fits};
    end
  end

  assign busy     = count != '0;
  assign quotient = work;

endmodule

// File: hdl/bpma_dp.sv
// Datapath: per-band totals, accumulate update, report capture and output register.
// Depends on bpma_pkg and bpma_div.
module bpma_dp
  import bpma_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_t      item_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       report_valid,
  input  logic       report_ready,
  output report_t    report_data
);

  logic [COUNT_BITS-1:0] cnt_tot [NUM_COUNTS][BAND_COUNT];
  logic [SUM_BITS-1:0]   sum_tot [NUM_SUMS][BAND_COUNT];

  logic [COUNT_BITS-1:0]   cnt_new [NUM_COUNTS];
  logic [SUM_BITS-1:0]     sum_new [NUM_SUMS];
  logic [NUM_COUNTS-1:0]   cnt_inc;
  logic [NUM_SUMS-1:0]     sum_inc;
  logic [BAND_IDX_BITS-1:0] band_idx;
  logic                    band_ok;
  logic                    clear_first;
  logic                    near;
  logic                    sat;
  logic                    g_one;
  logic                    g_two;

  logic [2:0]              rep_band;
  logic [COUNT_BITS-1:0]   rep_cnt [NUM_COUNTS];
  logic [SUM_BITS-1:0]     rep_sum [NUM_SUMS];
  logic [DIVISOR_BITS-1:0] rep_n   [NUM_SUMS];
  logic [SUM_BITS-1:0]     mean    [NUM_SUMS];

  logic [DIV_BITS-1:0]     div_q;
  logic [DIV_BITS-1:0]     div_dividend;
  logic [DIVISOR_BITS-1:0] div_divisor;
  logic                    div_busy;
  logic                    div_done;

  assign band_idx    = BAND_IDX_BITS'(item_data.band);
  assign band_ok     = 32'(item_data.band) < BAND_COUNT;
  assign clear_first = item_data.first_of_scan && (item_data.scan_number == '0);
  assign near        = {1'b0, item_data.sample} < ({1'b0, item_data.dark_level} + NEAR_MARGIN);
  assign sat         = item_data.sample >= SAT_LEVEL;
  assign g_one       = item_data.gain_code == GAIN_ONE;
  assign g_two       = item_data.gain_code == GAIN_TWO;

  always_comb begin
    cnt_inc                = '0;
    cnt_inc[CNT_NEAR]      = near;
    cnt_inc[CNT_ONE_SAT]   = g_one && sat;
    cnt_inc[CNT_ONE_UNSAT] = g_one && !sat;
    cnt_inc[CNT_TWO_SAT]   = g_two && sat;
    cnt_inc[CNT_TWO_UNSAT] = g_two && !sat;
    sum_inc                = '0;
    sum_inc[SUM_ONE]       = g_one;
    sum_inc[SUM_TWO]       = g_two;
  end

  always_comb begin
    logic [COUNT_BITS-1:0] cbase;
    logic [SUM_BITS-1:0]   sbase;
    logic [SUM_BITS:0]     swide;
    for (int k = 0; k < NUM_COUNTS; k++) begin
      cbase = clear_first ? '0 : cnt_tot[k][band_idx];
      cnt_new[k] = (cnt_inc[k] && (cbase != {COUNT_BITS{1'b1}})) ? cbase + 1'b1 : cbase;
    end
    for (int j = 0; j < NUM_SUMS; j++) begin
      sbase = clear_first ? '0 : sum_tot[j][band_idx];
      swide = {1'b0, sbase} + (sum_inc[j] ? (SUM_BITS+1)'(item_data.sample) : '0);
      sum_new[j] = swide[SUM_BITS] ? {SUM_BITS{1'b1}} : swide[SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < BAND_COUNT; b++) begin
      for (int k = 0; k < NUM_COUNTS; k++) begin
        if (rst || cmd.clr_all) begin
          cnt_tot[k][b] <= '0;
        end else if (cmd.acc_en && band_ok && (band_idx == BAND_IDX_BITS'(b))) begin
          cnt_tot[k][b] <= cnt_new[k];
        end else if (cmd.acc_en && clear_first) begin
          cnt_tot[k][b] <= '0;
        end
      end
      for (int j = 0; j < NUM_SUMS; j++) begin
        if (rst || cmd.clr_all) begin
          sum_tot[j][b] <= '0;
        end else if (cmd.acc_en && band_ok && (band_idx == BAND_IDX_BITS'(b))) begin
          sum_tot[j][b] <= sum_new[j];
        end else if (cmd.acc_en && clear_first) begin
          sum_tot[j][b] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rep_band <= item_data.band;
      for (int k = 0; k < NUM_COUNTS; k++) begin
        rep_cnt[k] <= band_ok ? cnt_tot[k][band_idx] : '0;
      end
      for (int j = 0; j < NUM_SUMS; j++) begin
        rep_sum[j] <= band_ok ? sum_tot[j][band_idx] : '0;
      end
      rep_n[SUM_ONE] <= band_ok ? DIVISOR_BITS'(cnt_tot[CNT_ONE_SAT][band_idx])
                                + DIVISOR_BITS'(cnt_tot[CNT_ONE_UNSAT][band_idx]) : '0;
      rep_n[SUM_TWO] <= band_ok ? DIVISOR_BITS'(cnt_tot[CNT_TWO_SAT][band_idx])
                                + DIVISOR_BITS'(cnt_tot[CNT_TWO_UNSAT][band_idx]) : '0;
    end
    if (cmd.store_one) begin
      mean[SUM_ONE] <= (rep_n[SUM_ONE] == '0) ? rep_sum[SUM_ONE] : div_q[SUM_BITS-1:0];
    end
    if (cmd.store_two) begin
      mean[SUM_TWO] <= (rep_n[SUM_TWO] == '0) ? rep_sum[SUM_TWO] : div_q[SUM_BITS-1:0];
    end
  end

  assign div_dividend = {rep_sum[cmd.div_sel], {FRAC_BITS{1'b0}}};
  assign div_divisor  = rep_n[cmd.div_sel];

  bpma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .busy     (div_busy),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (cmd.out_load) begin
      report_valid <= 1'b1;
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      report_data.report_band          <= rep_band;
      report_data.near_dark_count      <= clip_count(rep_cnt[CNT_NEAR]);
      report_data.gain_one_saturated   <= clip_count(rep_cnt[CNT_ONE_SAT]);
      report_data.gain_one_unsaturated <= clip_count(rep_cnt[CNT_ONE_UNSAT]);
      report_data.gain_two_saturated   <= clip_count(rep_cnt[CNT_TWO_SAT]);
      report_data.gain_two_unsaturated <= clip_count(rep_cnt[CNT_TWO_UNSAT]);
      report_data.gain_one_mean        <= mean[SUM_ONE];
      report_data.gain_two_mean        <= mean[SUM_TWO];
    end
  end

  assign status = '{div_busy: div_busy, div_done: div_done, out_busy: report_valid};

endmodule

// File: hdl/bpma_ctrl.sv
// Controller: accepts words, sequences the two mean divisions and the output load.
// Depends on bpma_pkg.
module bpma_ctrl
  import bpma_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] command,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START1 = 3'd1;
  localparam logic [2:0] S_WAIT1  = 3'd2;
  localparam logic [2:0] S_START2 = 3'd3;
  localparam logic [2:0] S_WAIT2  = 3'd4;
  localparam logic [2:0] S_HOLD   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign item_ready = state == S_IDLE;
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.acc_en  = accept && (command == CMD_ACCUMULATE);
        cmd.clr_all = accept && (command == CMD_CLEAR);
        cmd.capture = accept && (command == CMD_REPORT);
        if (accept && (command == CMD_REPORT)) begin
          state_next = S_START1;
        end
      end
      S_START1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b0;
        state_next    = S_WAIT1;
      end
      S_WAIT1: begin
        cmd.div_sel = 1'b0;
        if (status.div_done) begin
          cmd.store_one = 1'b1;
          state_next    = S_START2;
        end
      end
      S_START2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = S_WAIT2;
      end
      S_WAIT2: begin
        cmd.div_sel = 1'b1;
        if (status.div_done) begin
          cmd.store_two = 1'b1;
          state_next    = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
